/* rtl/gemv_transposed_accumulate_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the transposed GEMV block
// Shared clocking and reset handling for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef GEMV_TRANSPOSED_ACCUMULATE_DEFINES_SVH
`define GEMV_TRANSPOSED_ACCUMULATE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define GTA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gta checker: same-cycle implication failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define GTA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gta checker: next-cycle implication failed");

`endif

/* rtl/gta_pkg.sv */
// ----------------------------------------------------------------------------
// gta_pkg
// Types, constants and arithmetic helpers of the transposed GEMV block.
// ----------------------------------------------------------------------------
package gta_pkg;

  localparam int unsigned FracBits     = 24;
  localparam int unsigned RndBits      = 40;
  localparam int unsigned AlphaMagBits = 41;
  localparam int unsigned TotalBits    = 43;

  // Cap on the magnitude of the alpha term: 2^40.
  localparam logic [AlphaMagBits-1:0] AlphaCap = AlphaMagBits'(64'd1 << 40);

  localparam logic [31:0] AlphaReset = 32'd16777216;
  localparam logic [31:0] BetaReset  = 32'd0;
  localparam logic [16:0] RowsReset  = 17'd1;
  localparam logic [6:0]  ColsReset  = 7'd64;
  localparam logic [16:0] RowsMax    = 17'd65536;

  typedef enum logic [1:0] {
    CFG_ALPHA = 2'd0,
    CFG_BETA  = 2'd1,
    CFG_ROWS  = 2'd2,
    CFG_COLS  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    REQ_LOAD_Y = 1'b0,
    REQ_MATRIX = 1'b1
  } req_type_e;

  typedef enum logic {
    OP_LOAD_Y = 1'b0,
    OP_MAC    = 1'b1
  } op_e;

  typedef struct packed {
    logic               req_type;
    logic        [15:0] row_index;
    logic        [5:0]  col_index;
    logic signed [31:0] matrix_value;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic        [5:0]  result_col;
    logic               saturated;
  } res_t;

  typedef struct packed {
    logic signed [31:0] alpha_gain;
    logic signed [31:0] beta_gain;
    logic        [16:0] row_count;
    logic        [6:0]  col_count;
  } cfg_t;

  // Classified word handed from the front to the back. For a y load a_val
  // holds the raw y value; for a matrix word a_val and b_val hold the
  // magnitudes of the matrix element and of x, and neg the product sign.
  typedef struct packed {
    op_e         op;
    logic [5:0]  col;
    logic        first_row;
    logic        last_row;
    logic        neg;
    logic [31:0] a_val;
    logic [31:0] b_val;
  } item_t;

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [63:0] mag64(logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  // Round to nearest, ties away from zero, dropping the fraction bits of a
  // magnitude. Inputs never exceed 2^63, so the add cannot carry out.
  function automatic logic [RndBits-1:0] round_mag(logic [63:0] p);
    logic [63:0] s;
    s = p + (64'd1 << (FracBits - 1));
    return s[63:FracBits];
  endfunction

endpackage

/* rtl/gta_ram.sv */
// ----------------------------------------------------------------------------
// gta_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module gta_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/gta_fifo.sv */
// ----------------------------------------------------------------------------
// gta_fifo
// Small register FIFO with first-word-fall-through read side.
// ----------------------------------------------------------------------------
module gta_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slots[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots[wptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/gta_front.sv */
// ----------------------------------------------------------------------------
// gta_front
// Accepts input words, drops y loads beyond MAX_COLS-1 and matrix words outside
// the configured shape, and queues the rest in classified form for gta_back.
// ----------------------------------------------------------------------------
module gta_front #(
  parameter int unsigned MAX_COLS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gta_pkg::cfg_t   cfg_i,
  input  logic            push_i,
  input  gta_pkg::req_t   req_i,
  output logic            full_o,
  input  logic            q_pop_i,
  output gta_pkg::item_t  q_item_o,
  output logic            q_empty_o
);

  logic [16:0]    rows_eff;
  logic [6:0]     cols_eff;
  logic           is_y, y_ok, row_ok, col_ok, keep;
  gta_pkg::item_t item;

  always_comb begin
    if (cfg_i.row_count == '0) begin
      rows_eff = 17'd1;
    end else if (cfg_i.row_count > gta_pkg::RowsMax) begin
      rows_eff = gta_pkg::RowsMax;
    end else begin
      rows_eff = cfg_i.row_count;
    end

    // The clamp to MAX_COLS only applies when it is below col_count, so it
    // always fits the column count width.
    if (cfg_i.col_count == '0) begin
      cols_eff = 7'd1;
    end else if (32'(cfg_i.col_count) > MAX_COLS) begin
      cols_eff = 7'(MAX_COLS);
    end else begin
      cols_eff = cfg_i.col_count;
    end

    is_y   = (req_i.req_type == gta_pkg::REQ_LOAD_Y);
    y_ok   = (32'(req_i.col_index) < MAX_COLS);
    row_ok = ({1'b0, req_i.row_index} < rows_eff);
    col_ok = ({1'b0, req_i.col_index} < cols_eff);
    keep   = is_y ? y_ok : (row_ok && col_ok);

    item.op        = is_y ? gta_pkg::OP_LOAD_Y : gta_pkg::OP_MAC;
    item.col       = req_i.col_index;
    item.first_row = (req_i.row_index == '0);
    item.last_row  = ({1'b0, req_i.row_index} == (rows_eff - 17'd1));
    item.neg       = req_i.matrix_value[31] ^ req_i.x_value[31];
    item.a_val     = is_y ? req_i.y_value : gta_pkg::mag32(req_i.matrix_value);
    item.b_val     = gta_pkg::mag32(req_i.x_value);
  end

  gta_fifo #(
    .WIDTH ($bits(gta_pkg::item_t)),
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && keep),
    .wdata_i (item),
    .full_o  (full_o),
    .pop_i   (q_pop_i),
    .rdata_o (q_item_o),
    .empty_o (q_empty_o)
  );

endmodule

/* rtl/gta_back.sv */
// ----------------------------------------------------------------------------
// gta_back
// Sequencer that updates the column accumulators and forms each finished
// column result with one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module gta_back #(
  parameter int unsigned MAX_COLS = 64,
  localparam int unsigned AddrW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gta_pkg::cfg_t  cfg_i,
  input  gta_pkg::item_t q_item_i,
  input  logic           q_empty_i,
  output logic           q_pop_o,
  output gta_pkg::res_t  res_o,
  output logic           res_push_o,
  input  logic           res_full_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_MAG,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ALPHA,
    ST_BETA,
    ST_OUT
  } state_e;

  localparam logic signed [gta_pkg::TotalBits-1:0] SatHi = gta_pkg::TotalBits'(32'h7FFF_FFFF);
  localparam logic signed [gta_pkg::TotalBits-1:0] SatLo = ~SatHi;

  state_e state_q, state_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] preg_q, plo_q;
  logic [63:0] acc_q, acc_mag_q, acc_new, acc_rdata;
  logic [31:0] y_q, y_mag_q, y_rdata;
  logic [5:0]  col_q;
  logic        first_q, last_q, neg_q;
  logic [gta_pkg::AlphaMagBits-1:0]   alpha_mag_q, alpha_mag_d, alpha_sum;
  logic signed [gta_pkg::TotalBits-1:0] alpha_q, beta_q, total;
  logic signed [gta_pkg::TotalBits-1:0] alpha_d, beta_d;
  logic [gta_pkg::RndBits-1:0] prod_mag, beta_mag;
  logic [63:0] prod64, sum64;
  logic        ovf;
  logic        y_we, rd_en;

  assign q_pop_o = (state_q == ST_IDLE) && !q_empty_i;
  assign y_we    = q_pop_o && (q_item_i.op == gta_pkg::OP_LOAD_Y);
  assign rd_en   = q_pop_o && (q_item_i.op == gta_pkg::OP_MAC);

  gta_ram #(
    .WIDTH (32),
    .DEPTH (MAX_COLS)
  ) u_y_ram (
    .clk_i   (clk_i),
    .we_i    (y_we),
    .waddr_i (AddrW'(q_item_i.col)),
    .wdata_i (q_item_i.a_val),
    .re_i    (rd_en),
    .raddr_i (AddrW'(q_item_i.col)),
    .rdata_o (y_rdata)
  );

  gta_ram #(
    .WIDTH (64),
    .DEPTH (MAX_COLS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_ACC),
    .waddr_i (AddrW'(col_q)),
    .wdata_i (acc_new),
    .re_i    (rd_en),
    .raddr_i (AddrW'(q_item_i.col)),
    .rdata_o (acc_rdata)
  );

  // Operand select for the shared multiplier.
  always_comb begin
    case (state_q)
      ST_MUL_LO: begin
        mul_a = acc_mag_q[31:0];
        mul_b = gta_pkg::mag32(cfg_i.alpha_gain);
      end
      ST_MUL_HI: begin
        mul_a = acc_mag_q[63:32];
        mul_b = gta_pkg::mag32(cfg_i.alpha_gain);
      end
      ST_ALPHA: begin
        mul_a = y_mag_q;
        mul_b = gta_pkg::mag32(cfg_i.beta_gain);
      end
      default: begin
        mul_a = q_item_i.a_val;
        mul_b = q_item_i.b_val;
      end
    endcase
  end

  // Accumulator update with saturation at the signed 64-bit limits.
  always_comb begin
    prod_mag = gta_pkg::round_mag(preg_q);
    prod64   = neg_q ? (~64'(prod_mag) + 64'd1) : 64'(prod_mag);
    sum64    = acc_rdata + prod64;
    ovf      = (acc_rdata[63] == prod64[63]) && (sum64[63] != prod64[63]);
    if (first_q) begin
      acc_new = prod64;
    end else if (ovf) begin
      acc_new = prod64[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      acc_new = sum64;
    end
  end

  // Alpha term magnitude from the two partial products, capped at 2^40.
  always_comb begin
    alpha_sum = (gta_pkg::AlphaMagBits'(preg_q[31:0]) << (32 - gta_pkg::FracBits))
              + gta_pkg::AlphaMagBits'(gta_pkg::round_mag(plo_q));
    if ((preg_q[63:32] != '0) || (alpha_sum > gta_pkg::AlphaCap)) begin
      alpha_mag_d = gta_pkg::AlphaCap;
    end else begin
      alpha_mag_d = alpha_sum;
    end
  end

  always_comb begin
    beta_mag = gta_pkg::round_mag(preg_q);
    if (acc_q[63] ^ cfg_i.alpha_gain[31]) begin
      alpha_d = -$signed(gta_pkg::TotalBits'(alpha_mag_q));
    end else begin
      alpha_d = $signed(gta_pkg::TotalBits'(alpha_mag_q));
    end
    if (y_q[31] ^ cfg_i.beta_gain[31]) begin
      beta_d = -$signed(gta_pkg::TotalBits'(beta_mag));
    end else begin
      beta_d = $signed(gta_pkg::TotalBits'(beta_mag));
    end
    total = alpha_q + beta_q;
  end

  always_comb begin
    res_o.result_col = col_q;
    if (total > SatHi) begin
      res_o.result_value = SatHi[31:0];
      res_o.saturated    = 1'b1;
    end else if (total < SatLo) begin
      res_o.result_value = SatLo[31:0];
      res_o.saturated    = 1'b1;
    end else begin
      res_o.result_value = total[31:0];
      res_o.saturated    = 1'b0;
    end
  end

  assign res_push_o = (state_q == ST_OUT);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (rd_en) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC:    state_d = last_q ? ST_MAG : ST_IDLE;
      ST_MAG:    state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_ALPHA;
      ST_ALPHA:  state_d = ST_BETA;
      ST_BETA:   state_d = ST_OUT;
      ST_OUT: begin
        if (!res_full_i) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    preg_q <= mul_a * mul_b;
    if (rd_en) begin
      col_q   <= q_item_i.col;
      first_q <= q_item_i.first_row;
      last_q  <= q_item_i.last_row;
      neg_q   <= q_item_i.neg;
    end
    if (state_q == ST_ACC) begin
      acc_q <= acc_new;
      y_q   <= y_rdata;
    end
    if (state_q == ST_MAG) begin
      acc_mag_q <= gta_pkg::mag64(acc_q);
      y_mag_q   <= gta_pkg::mag32(y_q);
    end
    if (state_q == ST_MUL_HI) begin
      plo_q <= preg_q;
    end
    if (state_q == ST_ALPHA) begin
      alpha_mag_q <= alpha_mag_d;
    end
    if (state_q == ST_BETA) begin
      alpha_q <= alpha_d;
      beta_q  <= beta_d;
    end
  end

endmodule

/* rtl/gemv_transposed_accumulate.sv */
// ----------------------------------------------------------------------------
// gemv_transposed_accumulate
// Streaming dst = alpha * transpose(A) * x + beta * y over a row-major matrix.
// ----------------------------------------------------------------------------
// Usage. The input side behaves like a queue: a word is taken on a rising
// edge with push high and full low. A y-load word stores y[col]; a matrix word
// carries A[row][col] with x[row]. Matrix words outside the configured shape,
// and y loads with a column at or above MAX_COLS, are taken and dropped. The
// result side is a queue too: while empty is low the oldest result sits on
// res_o and leaves with pop high. Each last-row matrix word yields one result.
// Configuration writes go through cfg_valid_i/cfg_ready_o (always ready) and
// must only happen while the block is idle.
// Sequencing. A y load retires as the back end pops it; a matrix word of an
// inner row takes an accumulator RAM read then write; a last-row word then
// steps on through ST_MAG, ST_MUL_LO, ST_MUL_HI, ST_ALPHA, ST_BETA and ST_OUT,
// as the back end runs alpha*acc as two 32x32 partial products and beta*y on
// one shared multiplier. A two-word queue decouples the front from the back,
// and a two-word result queue lets the receiver stall without blocking input
// until both queues fill. Reset empties both queues and loads the register
// defaults; the y and accumulator RAMs are not cleared.
// ----------------------------------------------------------------------------
module gemv_transposed_accumulate #(
  parameter int unsigned MAX_COLS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Input word channel.
  input  logic          push,
  input  gta_pkg::req_t req_i,
  output logic          full,
  // Result channel.
  output logic          empty,
  input  logic          pop,
  output gta_pkg::res_t res_o,
  // Register write channel.
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);

  gta_pkg::cfg_t  cfg_q, cfg_d;
  gta_pkg::item_t q_item;
  gta_pkg::res_t  back_res;
  logic           q_empty, q_pop;
  logic           res_push, res_full;

  // The register file is always ready; software must only write it while idle (the block does not enforce this).
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (gta_pkg::cfg_idx_e'(cfg_index_i))
        gta_pkg::CFG_ALPHA: cfg_d.alpha_gain = cfg_data_i;
        gta_pkg::CFG_BETA:  cfg_d.beta_gain  = cfg_data_i;
        gta_pkg::CFG_ROWS:  cfg_d.row_count  = cfg_data_i[16:0];
        gta_pkg::CFG_COLS:  cfg_d.col_count  = cfg_data_i[6:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha_gain <= gta_pkg::AlphaReset;
      cfg_q.beta_gain  <= gta_pkg::BetaReset;
      cfg_q.row_count  <= gta_pkg::RowsReset;
      cfg_q.col_count  <= gta_pkg::ColsReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: shape checks, operand magnitudes, and the decoupling queue.
  gta_front #(
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .push_i    (push),
    .req_i     (req_i),
    .full_o    (full),
    .q_pop_i   (q_pop),
    .q_item_o  (q_item),
    .q_empty_o (q_empty)
  );

  // Back end: accumulator read-modify-write and the result arithmetic.
  gta_back #(
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_item_i   (q_item),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .res_o      (back_res),
    .res_push_o (res_push),
    .res_full_i (res_full)
  );

  // Result queue in front of the receiver.
  gta_fifo #(
    .WIDTH ($bits(gta_pkg::res_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_o),
    .empty_o (empty)
  );

endmodule

/* rtl/gta_checker.sv */
// ----------------------------------------------------------------------------
// gta_checker
// Port-level checks of the transposed GEMV block, bound to its top level.
// ----------------------------------------------------------------------------
`include "gemv_transposed_accumulate_defines.svh"

module gta_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          push,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input gta_pkg::res_t res_o
);

  // A waiting result stays put until it is taken.
  `GTA_ASSERT_NXT(a_result_holds, !empty && !pop, !empty && $stable(res_o))

  // The input queue only fills up through an accepted word.
  `GTA_ASSERT_NXT(a_full_needs_push, !full && !push, !full)

  // A clipped result sits exactly on one of the two limits.
  `GTA_ASSERT_IMP(a_sat_at_limit, !empty && res_o.saturated,
    res_o.result_value == 32'sh7FFF_FFFF || res_o.result_value == 32'sh8000_0000)

endmodule

bind gemv_transposed_accumulate gta_checker u_checker (.*);
